>>> sv/sbl_pkg.sv
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared types, character codes and helpers for the source byte lexer.
// ----------------------------------------------------------------------------
package sbl_pkg;

    // datapath widths
    localparam int OFFSET_BITS = 24;
    localparam int VALUE_BITS  = 32;

    // name length counter saturates at 256, one bit above the 8-bit limit
    localparam int NAME_LIMIT_BITS = 8;
    localparam int NAME_LEN_BITS   = NAME_LIMIT_BITS + 1;
    localparam logic [NAME_LIMIT_BITS-1:0] NAME_LIMIT_RESET = 8'd32;

    // token queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_VTAB       = 8'h0B;
    localparam logic [7:0] CH_FORMFEED   = 8'h0C;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_AMP        = 8'h26;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    // token kinds
    typedef enum logic [3:0] {
        KIND_END      = 4'd0,
        KIND_NAME     = 4'd1,
        KIND_INT      = 4'd2,
        KIND_EQ       = 4'd3,
        KIND_LE       = 4'd4,
        KIND_GE       = 4'd5,
        KIND_NE       = 4'd6,
        KIND_PUNCT    = 4'd7,
        KIND_LONGNAME = 4'd8,
        KIND_BADCHAR  = 4'd9,
        KIND_LINE     = 4'd10,
        KIND_BADSLASH = 4'd11
    } kind_t;

    // scanner modes
    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_NAME    = 6'b000010,
        MODE_INT     = 6'b000100,
        MODE_PAIR    = 6'b001000,
        MODE_SLASH   = 6'b010000,
        MODE_COMMENT = 6'b100000
    } mode_t;

    // one result token
    typedef struct packed {
        kind_t                  kind;
        logic [7:0]             symbol;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] end_offset;
        logic [VALUE_BITS-1:0]  int_value;
        logic                   overflow;
        logic                   last;
    } token_t;

    // up to two tokens produced by one byte
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } token_pair_t;

    // letters, digits and underscore continue a name
    function automatic logic is_name_char(input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        case (b) inside
            [CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z], [CH_DIGIT_0:CH_DIGIT_9],
            CH_UNDERSCORE: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        case (b) inside
            [CH_DIGIT_0:CH_DIGIT_9]: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

>>> sv/source_byte_lexer_unit.sv
// ----------------------------------------------------------------------------
// source_byte_lexer_unit
// Streaming lexer: source bytes in, tokens out, one byte per clock while the token queue has room.
// ----------------------------------------------------------------------------
// The lexer takes one source byte per cycle, while the token queue has room,
// into an input register and scans it there against the open token; the
// byte's tokens (none, one or two) go into a four-entry token queue, and the
// output side delivers one token per cycle, unless stalled, from the head of
// that queue. Input stays at one byte per cycle as long as bytes produce at
// most one token each on average and the output is not stalled; a byte that
// closes a name, integer, pair or slash and also makes a token of its own
// yields two tokens, and the single-token output port sets the rate then. A
// zero byte ends the source, gives an end token and restarts offsets at zero.
// max_name_length is written through config_write and config_data; the user
// must write it only while no request is open, the block does not enforce it.
// ----------------------------------------------------------------------------
module source_byte_lexer_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            source_valid,
    output logic                            source_stall,
    input  logic [7:0]                      source_byte,
    input  logic                            config_write,
    input  logic [7:0]                      config_data,
    output logic                            token_valid,
    input  logic                            token_stall,
    output logic [3:0]                      tok_kind,
    output logic [7:0]                      symbol,
    output logic [sbl_pkg::OFFSET_BITS-1:0] start_offset,
    output logic [sbl_pkg::OFFSET_BITS-1:0] end_offset,
    output logic [sbl_pkg::VALUE_BITS-1:0]  int_value,
    output logic                            overflow,
    output logic                            last
);

    sbl_pkg::token_pair_t push;
    sbl_pkg::token_t      head;
    logic                 room;

    // byte scanner
    sbl_scanner u_scanner
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_valid (source_valid),
        .source_stall (source_stall),
        .source_byte  (source_byte),
        .config_write (config_write),
        .config_data  (config_data),
        .room         (room),
        .push         (push)
    );

    // token queue
    sbl_token_queue u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .room        (room),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .head        (head)
    );

    // token fields
    assign tok_kind     = head.kind;
    assign symbol       = head.symbol;
    assign start_offset = head.start_offset;
    assign end_offset   = head.end_offset;
    assign int_value    = head.int_value;
    assign overflow     = head.overflow;
    assign last         = head.last;

endmodule

>>> sv/sbl_token_queue.sv
// ----------------------------------------------------------------------------
// sbl_token_queue
// Small token queue: takes up to two tokens a cycle, delivers one a cycle unless stalled.
// ----------------------------------------------------------------------------
module sbl_token_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sbl_pkg::token_pair_t push,
    output logic                 room,
    output logic                 token_valid,
    input  logic                 token_stall,
    output sbl_pkg::token_t      head
);

    sbl_pkg::token_t entry_reg [sbl_pkg::QUEUE_DEPTH];

    logic [sbl_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sbl_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sbl_pkg::QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic [sbl_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_plus1;
    logic                               pop;

    // status toward both sides
    assign token_valid  = (count_reg != '0);
    assign room         = (count_reg <= sbl_pkg::QUEUE_CNT_BITS'(sbl_pkg::QUEUE_DEPTH - 2));
    assign head         = entry_reg[rd_ptr_reg];
    assign pop          = token_valid && !token_stall;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + sbl_pkg::QUEUE_PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + sbl_pkg::QUEUE_PTR_BITS'(pop);
        count_next  = count_reg + sbl_pkg::QUEUE_CNT_BITS'(push.count)
                      - sbl_pkg::QUEUE_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // token storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

>>> sv/sbl_scanner.sv
// ----------------------------------------------------------------------------
// sbl_scanner
// Input byte register and scanner state: lexes one byte a cycle into tokens while the queue has room.
// ----------------------------------------------------------------------------
module sbl_scanner
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 source_valid,
    output logic                 source_stall,
    input  logic [7:0]           source_byte,
    input  logic                 config_write,
    input  logic [7:0]           config_data,
    input  logic                 room,
    output sbl_pkg::token_pair_t push
);

    localparam int OB = sbl_pkg::OFFSET_BITS;
    localparam int VB = sbl_pkg::VALUE_BITS;
    localparam int WB = VB + 4;

    // input register
    logic       byte_valid_reg, byte_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       accept;
    logic       consume;

    // scanner state
    sbl_pkg::mode_t                    mode_reg, mode_next;
    logic [OB-1:0]                     offset_reg, offset_next;
    logic [OB-1:0]                     tok_start_reg, tok_start_next;
    logic [VB-1:0]                     value_reg, value_next;
    logic                              sat_reg, sat_next;
    logic [sbl_pkg::NAME_LEN_BITS-1:0] name_len_reg, name_len_next;
    logic [7:0]                        pending_reg, pending_next;
    logic [7:0]                        max_len_reg, max_len_next;

    // step results
    logic [OB-1:0]  off_plus1;
    logic [3:0]     digit;
    logic [WB-1:0]  wide_value;
    logic           fresh_emit;
    sbl_pkg::kind_t fresh_kind;
    logic [7:0]     fresh_symbol;
    logic [OB-1:0]  fresh_start;
    sbl_pkg::mode_t fresh_mode;
    logic           use_fresh;
    logic           flush_emit;
    sbl_pkg::token_t flush_tok;
    sbl_pkg::token_t fresh_tok;
    sbl_pkg::mode_t step_mode;
    logic [OB-1:0]  step_tok_start;
    logic [VB-1:0]  step_value;
    logic           step_sat;
    logic [sbl_pkg::NAME_LEN_BITS-1:0] step_name_len;
    logic [7:0]     step_pending;
    logic           emit_fresh;

    // handshake: hold the byte while the queue lacks room for two tokens
    assign source_stall = byte_valid_reg && !room;
    assign accept       = source_valid && !source_stall;
    assign consume      = byte_valid_reg && room;

    assign off_plus1  = offset_reg + 1'b1;
    assign digit      = 4'(byte_reg - sbl_pkg::CH_DIGIT_0);
    assign wide_value = ({4'b0, value_reg} << 3) + ({4'b0, value_reg} << 1)
                        + WB'(digit);

    // classify the byte as the start of a new token
    always_comb
    begin
        fresh_emit   = 1'b0;
        fresh_kind   = sbl_pkg::KIND_BADCHAR;
        fresh_symbol = 8'd0;
        fresh_start  = offset_reg;
        fresh_mode   = sbl_pkg::MODE_IDLE;
        case (byte_reg) inside
            sbl_pkg::CH_NUL:
            begin
                fresh_emit = 1'b1;
                fresh_kind = sbl_pkg::KIND_END;
            end
            sbl_pkg::CH_NEWLINE:
            begin
                fresh_emit  = 1'b1;
                fresh_kind  = sbl_pkg::KIND_LINE;
                fresh_start = off_plus1;
            end
            sbl_pkg::CH_SPACE, sbl_pkg::CH_TAB, sbl_pkg::CH_VTAB, sbl_pkg::CH_CR,
            sbl_pkg::CH_FORMFEED:
            begin
                fresh_emit = 1'b0;
            end
            [sbl_pkg::CH_UPPER_A:sbl_pkg::CH_UPPER_Z],
            [sbl_pkg::CH_LOWER_A:sbl_pkg::CH_LOWER_Z], sbl_pkg::CH_UNDERSCORE:
            begin
                fresh_mode = sbl_pkg::MODE_NAME;
            end
            [sbl_pkg::CH_DIGIT_0:sbl_pkg::CH_DIGIT_9]:
            begin
                fresh_mode = sbl_pkg::MODE_INT;
            end
            sbl_pkg::CH_EQUAL, sbl_pkg::CH_LESS, sbl_pkg::CH_GREATER, sbl_pkg::CH_BANG:
            begin
                fresh_mode = sbl_pkg::MODE_PAIR;
            end
            sbl_pkg::CH_SLASH:
            begin
                fresh_mode = sbl_pkg::MODE_SLASH;
            end
            sbl_pkg::CH_STAR, sbl_pkg::CH_AMP, sbl_pkg::CH_PLUS, sbl_pkg::CH_MINUS,
            sbl_pkg::CH_DOT, sbl_pkg::CH_LBRACKET, sbl_pkg::CH_RBRACKET,
            sbl_pkg::CH_COMMA, sbl_pkg::CH_SEMI, sbl_pkg::CH_COLON,
            sbl_pkg::CH_LPAREN, sbl_pkg::CH_RPAREN, sbl_pkg::CH_LBRACE,
            sbl_pkg::CH_RBRACE:
            begin
                fresh_emit   = 1'b1;
                fresh_kind   = sbl_pkg::KIND_PUNCT;
                fresh_symbol = byte_reg;
            end
            default:
            begin
                fresh_emit   = 1'b1;
                fresh_kind   = sbl_pkg::KIND_BADCHAR;
                fresh_symbol = byte_reg;
            end
        endcase
    end

    // continue or finish the open token
    always_comb
    begin
        use_fresh      = 1'b0;
        flush_emit     = 1'b0;
        flush_tok      = '0;
        flush_tok.kind = sbl_pkg::KIND_END;
        flush_tok.start_offset = tok_start_reg;
        flush_tok.end_offset   = offset_reg;
        step_mode      = mode_reg;
        step_tok_start = tok_start_reg;
        step_value     = value_reg;
        step_sat       = sat_reg;
        step_name_len  = name_len_reg;
        step_pending   = pending_reg;
        case (mode_reg)
            sbl_pkg::MODE_NAME:
            begin
                if (sbl_pkg::is_name_char(byte_reg))
                begin
                    if (!name_len_reg[sbl_pkg::NAME_LEN_BITS-1])
                    begin
                        step_name_len = name_len_reg + 1'b1;
                    end
                end
                else
                begin
                    flush_emit     = 1'b1;
                    flush_tok.kind = (name_len_reg > {1'b0, max_len_reg}) ?
                                     sbl_pkg::KIND_LONGNAME : sbl_pkg::KIND_NAME;
                    use_fresh      = 1'b1;
                end
            end
            sbl_pkg::MODE_INT:
            begin
                if (sbl_pkg::is_digit(byte_reg))
                begin
                    if (sat_reg || (wide_value[WB-1:VB] != 4'd0))
                    begin
                        step_value = '1;
                        step_sat   = 1'b1;
                    end
                    else
                    begin
                        step_value = wide_value[VB-1:0];
                    end
                end
                else
                begin
                    flush_emit          = 1'b1;
                    flush_tok.kind      = sbl_pkg::KIND_INT;
                    flush_tok.int_value = value_reg;
                    flush_tok.overflow  = sat_reg;
                    use_fresh           = 1'b1;
                end
            end
            sbl_pkg::MODE_PAIR:
            begin
                flush_emit = 1'b1;
                if (byte_reg == sbl_pkg::CH_EQUAL)
                begin
                    case (pending_reg)
                        sbl_pkg::CH_EQUAL:   flush_tok.kind = sbl_pkg::KIND_EQ;
                        sbl_pkg::CH_LESS:    flush_tok.kind = sbl_pkg::KIND_LE;
                        sbl_pkg::CH_GREATER: flush_tok.kind = sbl_pkg::KIND_GE;
                        default:             flush_tok.kind = sbl_pkg::KIND_NE;
                    endcase
                    flush_tok.end_offset = off_plus1;
                    step_mode            = sbl_pkg::MODE_IDLE;
                end
                else
                begin
                    flush_tok.kind   = sbl_pkg::KIND_PUNCT;
                    flush_tok.symbol = pending_reg;
                    use_fresh        = 1'b1;
                end
            end
            sbl_pkg::MODE_SLASH:
            begin
                if (byte_reg == sbl_pkg::CH_SLASH)
                begin
                    step_mode = sbl_pkg::MODE_COMMENT;
                end
                else
                begin
                    flush_emit     = 1'b1;
                    flush_tok.kind = sbl_pkg::KIND_BADSLASH;
                    use_fresh      = 1'b1;
                end
            end
            sbl_pkg::MODE_COMMENT:
            begin
                use_fresh = (byte_reg == sbl_pkg::CH_NEWLINE) || (byte_reg == sbl_pkg::CH_NUL);
            end
            default:
            begin
                use_fresh = 1'b1;
            end
        endcase

        // a new token starts at this byte
        if (use_fresh)
        begin
            step_mode      = fresh_mode;
            step_tok_start = offset_reg;
            step_value     = VB'(digit);
            step_sat       = 1'b0;
            step_name_len  = sbl_pkg::NAME_LEN_BITS'(1);
            step_pending   = byte_reg;
        end
    end

    // pack the tokens for the queue, the second only after a flush
    always_comb
    begin
        emit_fresh             = use_fresh && fresh_emit;
        fresh_tok              = '0;
        fresh_tok.kind         = fresh_kind;
        fresh_tok.symbol       = fresh_symbol;
        fresh_tok.start_offset = fresh_start;
        fresh_tok.end_offset   = off_plus1;
        fresh_tok.last         = 1'b1;
        push.second            = fresh_tok;
        push.first             = flush_emit ? flush_tok : fresh_tok;
        push.first.last        = !(flush_emit && emit_fresh);
        push.count             = consume ? (2'(flush_emit) + 2'(emit_fresh)) : 2'd0;
    end

    // next register values
    always_comb
    begin
        byte_valid_next = accept ? 1'b1 : (consume ? 1'b0 : byte_valid_reg);
        byte_next       = accept ? source_byte : byte_reg;
        max_len_next    = config_write ? config_data : max_len_reg;
        mode_next       = mode_reg;
        offset_next     = offset_reg;
        tok_start_next  = tok_start_reg;
        value_next      = value_reg;
        sat_next        = sat_reg;
        name_len_next   = name_len_reg;
        pending_next    = pending_reg;
        if (consume)
        begin
            if (byte_reg == sbl_pkg::CH_NUL)
            begin
                // end of source: restart positions
                mode_next      = sbl_pkg::MODE_IDLE;
                offset_next    = '0;
                tok_start_next = '0;
                value_next     = '0;
                sat_next       = 1'b0;
                name_len_next  = '0;
                pending_next   = 8'd0;
            end
            else
            begin
                mode_next      = step_mode;
                offset_next    = off_plus1;
                tok_start_next = step_tok_start;
                value_next     = step_value;
                sat_next       = step_sat;
                name_len_next  = step_name_len;
                pending_next   = step_pending;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            max_len_reg    <= sbl_pkg::NAME_LIMIT_RESET;
            mode_reg       <= sbl_pkg::MODE_IDLE;
            offset_reg     <= '0;
            tok_start_reg  <= '0;
            value_reg      <= '0;
            sat_reg        <= 1'b0;
            name_len_reg   <= '0;
            pending_reg    <= 8'd0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            max_len_reg    <= max_len_next;
            mode_reg       <= mode_next;
            offset_reg     <= offset_next;
            tok_start_reg  <= tok_start_next;
            value_reg      <= value_next;
            sat_reg        <= sat_next;
            name_len_reg   <= name_len_next;
            pending_reg    <= pending_next;
        end
    end

    // byte payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule
